@@ hdl/wbc_pkg.sv @@
// wbc_pkg: shared types and defaults for the word break checker
// used by wbc_cell and word_break_checker; depends on nothing

package wbc_pkg;

   // default sizes of the dictionary
   localparam int DEF_MAX_WORDS    = 16;
   localparam int DEF_MAX_WORD_LEN = 16;

   localparam int CHAR_W = 8;

   // request operation codes; code 3 is ignored
   typedef enum logic [1:0] {
      OP_DICT  = 2'd0,
      OP_TEXT  = 2'd1,
      OP_CLEAR = 2'd2
   } op_type;

   // control sent from the top level to every word cell
   typedef struct packed {
      logic              load;       // shift a dictionary character in
      logic              commit;     // word closes, take its length
      logic              clear;      // dictionary clear
      logic [CHAR_W-1:0] char_value;
   } cell_ctrl_type;

endpackage

@@ hdl/word_break_checker.sv @@
// word_break_checker: streaming word break test over a row of word cells
// uses wbc_pkg and wbc_cell
//
// Usage: a request carries op, char_value and last. Dictionary characters
// (OP_DICT) fill the next free word slot; last closes the word. Words longer
// than MAX_WORD_LEN, or closing with all MAX_WORDS slots full, are dropped and
// set the sticky dict_overflow flag. OP_CLEAR empties the dictionary and the
// flag. Text characters (OP_TEXT) each give one response: breakable is set
// when the string prefix up to this character splits into dictionary words,
// string_end copies last, after which the text state restarts.
// Dictionary, clear and undefined requests give no response.
// Throughput: one request per cycle unless a response stalls. A response is
// valid in the cycle after its request transfer; every word cell compares its
// whole word against the text window combinationally and the matches ripple
// down the cell row as an OR chain.
// Reset empties the dictionary, clears the overflow flag and restarts the text.
// The response sits in an output register; while it is stalled, a new request
// is taken only in a cycle in which that response transfers.

module word_break_checker
   import wbc_pkg::*;
#(
   parameter int MAX_WORDS    = DEF_MAX_WORDS,
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [1:0]        req_op,
   input  logic [CHAR_W-1:0] req_char_value,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_breakable,
   output logic              rsp_string_end,
   output logic              rsp_dict_overflow
);

   localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);
   localparam int FILL_W = $clog2(MAX_WORD_LEN + 2);
   localparam int CNT_W  = $clog2(MAX_WORDS + 1);

   logic                                req_xfer;
   logic                                dict_op;
   logic                                text_op;
   logic                                clear_op;
   logic                                store_ok;
   logic                                commit;
   logic [FILL_W-1:0]                   fill_ff;
   logic [FILL_W-1:0]                   fill_in;
   logic [FILL_W-1:0]                   fill_inc;
   logic [CNT_W-1:0]                    count_ff;
   logic [CNT_W-1:0]                    count_in;
   logic                                overflow_ff;
   logic                                overflow_in;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] window_ff;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] window_in;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] window_next;
   logic [MAX_WORD_LEN:0]               hist_ff;
   logic [MAX_WORD_LEN:0]               hist_in;
   logic [MAX_WORDS:0]                  hit_chain;
   logic [LEN_W-1:0]                    commit_len;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   logic                                breakable_ff;
   logic                                string_end_ff;
   logic                                dict_overflow_ff;

   // handshake and operation decode
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;
   assign dict_op   = req_xfer && (req_op == OP_DICT);
   assign text_op   = req_xfer && (req_op == OP_TEXT);
   assign clear_op  = req_xfer && (req_op == OP_CLEAR);

   // dictionary fill bookkeeping
   assign store_ok   = (count_ff < CNT_W'(MAX_WORDS)) && (fill_ff < FILL_W'(MAX_WORD_LEN));
   assign fill_inc   = fill_ff + FILL_W'(1);
   assign commit_len = fill_inc[LEN_W-1:0];
   assign commit     = dict_op && req_last && store_ok;

   always_comb begin
      fill_in     = fill_ff;
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (clear_op) begin
         fill_in     = '0;
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (dict_op) begin
         if (req_last) begin
            fill_in = '0;
            if (store_ok) begin
               count_in = count_ff + CNT_W'(1);
            end else begin
               overflow_in = 1'b1;
            end
         end else if (fill_ff <= FILL_W'(MAX_WORD_LEN)) begin
            fill_in = fill_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // text window with the new character in front
   always_comb begin
      window_next[0] = req_char_value;
      for (int i = 1; i < MAX_WORD_LEN; i++) begin
         window_next[i] = window_ff[i-1];
      end
   end

   // row of word cells, match bits ripple down the hit chain
   assign hit_chain[0] = 1'b0;

   for (genvar w = 0; w < MAX_WORDS; w++) begin : g_cell
      cell_ctrl_type ctrl;

      always_comb begin
         ctrl.load       = dict_op && store_ok && (count_ff == CNT_W'(w));
         ctrl.commit     = commit && (count_ff == CNT_W'(w));
         ctrl.clear      = clear_op;
         ctrl.char_value = req_char_value;
      end

      wbc_cell #(
         .MAX_WORD_LEN (MAX_WORD_LEN)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .commit_len (commit_len),
         .window     (window_next),
         .history    (hist_ff),
         .hit_in     (hit_chain[w]),
         .hit_out    (hit_chain[w+1])
      );
   end

   // text state update, restart after the final character of a string
   always_comb begin
      window_in = window_ff;
      hist_in   = hist_ff;
      if (text_op) begin
         if (req_last) begin
            window_in = '0;
            hist_in   = (MAX_WORD_LEN + 1)'(1);
         end else begin
            window_in = window_next;
            hist_in   = {hist_ff[MAX_WORD_LEN-1:0], hit_chain[MAX_WORDS]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         hist_ff   <= (MAX_WORD_LEN + 1)'(1);
      end else begin
         window_ff <= window_in;
         hist_ff   <= hist_in;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (text_op) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (text_op) begin
         breakable_ff     <= hit_chain[MAX_WORDS];
         string_end_ff    <= req_last;
         dict_overflow_ff <= overflow_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_breakable     = breakable_ff;
   assign rsp_string_end    = string_end_ff;
   assign rsp_dict_overflow = dict_overflow_ff;

   // word count never runs past the slot count
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_WORDS))
      else $error("word count past slot count");

   // fill position saturates one past the word length limit
   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(MAX_WORD_LEN + 1))
      else $error("fill position past saturation");

   // final text character restarts the history
   a_string_restart: assert property (@(posedge clock) disable iff (reset)
      text_op && req_last |=> hist_ff == (MAX_WORD_LEN + 1)'(1))
      else $error("history not restarted after string end");

   // every text transfer leaves a pending response
   a_text_response: assert property (@(posedge clock) disable iff (reset)
      text_op |=> rsp_valid_ff)
      else $error("text transfer without response");

endmodule

@@ hdl/wbc_cell.sv @@
// wbc_cell: one dictionary word slot; stores the word reversed, compares it
// against the text window and ORs its match into the hit chain; uses wbc_pkg

module wbc_cell
   import wbc_pkg::*;
#(
   parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN,
   localparam int LEN_W = $clog2(MAX_WORD_LEN + 1)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  cell_ctrl_type                           ctrl,
   input  logic [LEN_W-1:0]                        commit_len,
   input  logic [MAX_WORD_LEN-1:0][CHAR_W-1:0]     window,
   input  logic [MAX_WORD_LEN:0]                   history,
   input  logic                                    hit_in,
   output logic                                    hit_out
);

   // word characters, newest at index 0, so index i lines up with window[i]
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] chars_ff;
   logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] chars_in;
   logic [LEN_W-1:0]                    len_ff;
   logic [LEN_W-1:0]                    len_in;
   logic [LEN_W-1:0]                    len_m1;
   logic [MAX_WORD_LEN-1:0]             pos_ok;
   logic                                match;

   // character shift line, loaded while this slot is being filled
   always_comb begin
      chars_in = chars_ff;
      if (ctrl.load) begin
         chars_in[0] = ctrl.char_value;
         for (int i = 1; i < MAX_WORD_LEN; i++) begin
            chars_in[i] = chars_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   // committed length, zero means empty slot
   always_comb begin
      len_in = len_ff;
      if (ctrl.clear) begin
         len_in = '0;
      end else if (ctrl.commit) begin
         len_in = commit_len;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
      end else begin
         len_ff <= len_in;
      end
   end

   // per position compare, positions past the word length always pass
   always_comb begin
      for (int i = 0; i < MAX_WORD_LEN; i++) begin
         pos_ok[i] = (window[i] == chars_ff[i]) || (LEN_W'(i) >= len_ff);
      end
   end

   // word matches the suffix and the position before it was breakable
   assign len_m1  = len_ff - LEN_W'(1);
   assign match   = (len_ff != '0) && (&pos_ok) && history[len_m1];
   assign hit_out = hit_in | match;

endmodule

@@ bench/tb_word_break_checker.sv @@
// tb_word_break_checker: self-checking bench for the streaming word break checker
// depends on wbc_pkg and word_break_checker; drives a directed table, then random
// dictionaries and texts, and checks every response against its own prediction or the table

module tb_word_break_checker;
   import wbc_pkg::*;

   localparam int NW = DEF_MAX_WORDS;
   localparam int WL = DEF_MAX_WORD_LEN;

   // request code that the block must ignore
   localparam logic [1:0] OP_UNDEF = 2'd3;

   localparam int RAND_ITEMS   = 1250;
   localparam int HOLD_CYCLES  = 200;
   localparam int STALL_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 8;

   // idling per stage: none, sender, receiver, both
   localparam int GAP_PCT [4]   = '{0, 64, 0, 38};
   localparam int STALL_PCT [4] = '{0, 0, 64, 38};

   typedef struct packed {
      logic brk;
      logic at_end;
      logic overflow;
   } verdict_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  ch;
      logic        fin;
      logic        typed;
      verdict_type want;
   } dir_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [1:0]        req_op;
   logic [CHAR_W-1:0] req_char_value;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_breakable;
   logic              rsp_string_end;
   logic              rsp_dict_overflow;

   // predicted block state
   logic [7:0] dict_chars [NW*WL];
   logic [4:0] word_len [NW];
   logic [4:0] n_words;
   logic [4:0] fill_pos;
   logic [7:0] text_win [WL];
   logic [WL:0] brk_hist;
   logic        ovf_flag;

   verdict_type pending_verdicts [$];
   logic        typed_armed;
   verdict_type typed_want;
   logic        hold_pending;
   int          stage;
   int          items_sent;
   int          mismatches;
   int          idle_cycles;

   word_break_checker dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_char_value    (req_char_value),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_breakable     (rsp_breakable),
      .rsp_string_end    (rsp_string_end),
      .rsp_dict_overflow (rsp_dict_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic void empty_dictionary();
      for (int w = 0; w < NW; w++) begin
         word_len[w] = '0;
      end
      n_words  = '0;
      fill_pos = '0;
      ovf_flag = 1'b0;
   endfunction

   function automatic void restart_text();
      for (int i = 0; i < WL; i++) begin
         text_win[i] = '0;
      end
      brk_hist    = '0;
      brk_hist[0] = 1'b1;
   endfunction

   // advance the predicted state by one request, give the verdict of a text character
   task automatic step_word_break(input logic [1:0] op, input logic [7:0] ch, input logic fin,
                                  output logic has, output verdict_type v);
      logic hit;
      logic same;
      int   len;
      has = 1'b0;
      v   = '0;
      case (op)
         OP_DICT: begin
            if (n_words < NW && fill_pos < WL) begin
               dict_chars[int'(n_words)*WL + int'(fill_pos)] = ch;
            end
            // fill position saturates one past the limit: word too long
            if (fill_pos <= WL) begin
               fill_pos = fill_pos + 5'd1;
            end
            if (fin) begin
               if (fill_pos <= WL && n_words < NW) begin
                  word_len[n_words] = fill_pos;
                  n_words = n_words + 5'd1;
               end else begin
                  ovf_flag = 1'b1;
               end
               fill_pos = '0;
            end
         end
         OP_CLEAR: begin
            empty_dictionary();
         end
         OP_TEXT: begin
            for (int i = WL-1; i > 0; i--) begin
               text_win[i] = text_win[i-1];
            end
            text_win[0] = ch;
            hit = 1'b0;
            // a word matches when it ends the text and the spot before it was breakable
            for (int w = 0; w < n_words; w++) begin
               len = word_len[w];
               if (len != 0 && len <= WL && brk_hist[len-1]) begin
                  same = 1'b1;
                  for (int i = 0; i < len; i++) begin
                     if (text_win[i] != dict_chars[w*WL + len-1-i]) begin
                        same = 1'b0;
                     end
                  end
                  if (same) begin
                     hit = 1'b1;
                  end
               end
            end
            brk_hist = {brk_hist[WL-1:0], hit};
            v   = '{hit, fin, ovf_flag};
            has = 1'b1;
            if (fin) begin
               restart_text();
            end
         end
         default: begin
         end
      endcase
   endtask

   // offer one request; returns at the falling edge after its transfer
   task automatic send_req(input logic [1:0] op, input logic [7:0] ch, input logic fin,
                           input logic typed = 1'b0, input verdict_type want = '0);
      while (GAP_PCT[stage] != 0 && $urandom_range(99) < GAP_PCT[stage]) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      typed_armed = typed;
      typed_want  = want;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_char_value <= ch;
      req_last       <= fin;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      if (op != OP_UNDEF) begin
         items_sent++;
      end
   endtask

   // pause the sender until every expected response has come
   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_verdicts.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // receiver: random stalls per stage, one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_pending = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= STALL_PCT[stage]);
         end
      end
   end

   // transfer monitor: response check, request prediction, stall watchdog
   always @(posedge clock) begin : monitor
      verdict_type got;
      verdict_type want;
      logic        has;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            got = '{rsp_breakable, rsp_string_end, rsp_dict_overflow};
            if (pending_verdicts.size() == 0) begin
               report("response transfer with nothing expected");
            end else begin
               want = pending_verdicts.pop_front();
               if (got.brk !== want.brk)
                  report($sformatf("breakable got %b want %b", got.brk, want.brk));
               if (got.at_end !== want.at_end)
                  report($sformatf("string_end got %b want %b", got.at_end, want.at_end));
               if (got.overflow !== want.overflow)
                  report($sformatf("dict_overflow got %b want %b",
                                   got.overflow, want.overflow));
            end
         end
         if (req_valid && req_ready) begin
            idle_cycles = 0;
            step_word_break(req_op, req_char_value, req_last, has, want);
            if (has) begin
               if (typed_armed) begin
                  want = typed_want;
               end
               pending_verdicts.push_back(want);
            end
            typed_armed = 1'b0;
         end
         if (idle_cycles >= STALL_LIMIT) begin
            $display("word_break_checker verification failed");
            $finish;
         end
      end
   end

   // stimulus
   initial begin : stimulus
      dir_row_type dir_tab [25];
      logic [7:0]  alpha [4];
      logic [7:0]  words [20][20];
      int          wl [20];
      logic [7:0]  sbuf [64];
      logic        full_range;
      logic        fin;
      int          n_w;
      int          n_s;
      int          r;
      int          pick;
      int          slen;
      int          new_stage;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_op         = OP_DICT;
      req_char_value = '0;
      req_last       = 1'b0;
      typed_armed    = 1'b0;
      typed_want     = '0;
      hold_pending   = 1'b0;
      stage          = 0;
      items_sent     = 0;
      mismatches     = 0;
      empty_dictionary();
      restart_text();

      // empty dictionary, ignored code, too-long word, clear, unfinished word
      dir_tab = '{
         '{OP_TEXT,  8'h00, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b0}},
         '{OP_UNDEF, 8'hff, 1'b1, 1'b0, '0},
         '{OP_DICT,  8'h00, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'hff, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h01, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h80, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h55, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'haa, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'h7a, 1'b1, 1'b0, '0},
         '{OP_TEXT,  8'h7a, 1'b1, 1'b1, '{1'b0, 1'b1, 1'b1}},
         '{OP_CLEAR, 8'h00, 1'b0, 1'b0, '0},
         '{OP_DICT,  8'hff, 1'b1, 1'b0, '0},
         '{OP_DICT,  8'h71, 1'b0, 1'b0, '0},
         '{OP_TEXT,  8'hff, 1'b0, 1'b0, '0},
         '{OP_TEXT,  8'h71, 1'b1, 1'b0, '0}
      };

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      for (int i = 0; i < 25; i++) begin
         send_req(dir_tab[i].op, dir_tab[i].ch, dir_tab[i].fin, dir_tab[i].typed,
                  dir_tab[i].want);
      end
      drain();

      // random sessions: load a dictionary, then texts mostly built from its words
      items_sent   = 0;
      hold_pending = 1'b1;
      while (items_sent < RAND_ITEMS) begin
         new_stage = items_sent * 4 / RAND_ITEMS;
         if (new_stage > 3) begin
            new_stage = 3;
         end
         if (new_stage != stage) begin
            drain();
            stage = new_stage;
         end

         if ($urandom_range(3) != 0) begin
            send_req(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
         end

         full_range = ($urandom_range(3) == 0);
         for (int k = 0; k < 4; k++) begin
            alpha[k] = full_range ? 8'($urandom_range(255)) : 8'h61 + 8'($urandom_range(2));
         end

         // dictionary: now and then too many words or words too long
         n_w = ($urandom_range(7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 5);
         for (int k = 0; k < n_w; k++) begin
            r = $urandom_range(19);
            if (r == 0) begin
               wl[k] = $urandom_range(17, 19);
            end else if (r == 1) begin
               wl[k] = $urandom_range(14, 16);
            end else begin
               wl[k] = $urandom_range(1, 4);
            end
            for (int j = 0; j < wl[k]; j++) begin
               words[k][j] = alpha[$urandom_range(3)];
               send_req(OP_DICT, words[k][j], j == wl[k]-1);
            end
            if ($urandom_range(15) == 0) begin
               send_req(OP_UNDEF, 8'($urandom_range(255)), 1'($urandom_range(1)));
            end
         end

         // texts: word chains with some noise pieces
         n_s = $urandom_range(2, 6);
         for (int s = 0; s < n_s; s++) begin
            slen = 0;
            for (int p = $urandom_range(1, 7); p > 0; p--) begin
               if ($urandom_range(9) != 0) begin
                  pick = $urandom_range(n_w-1);
                  if (slen + wl[pick] <= 64) begin
                     for (int j = 0; j < wl[pick]; j++) begin
                        sbuf[slen] = words[pick][j];
                        slen++;
                     end
                  end
               end else begin
                  for (int j = $urandom_range(1, 3); j > 0 && slen < 64; j--) begin
                     sbuf[slen] = ($urandom_range(7) == 0) ? 8'($urandom_range(255))
                                                           : alpha[$urandom_range(3)];
                     slen++;
                  end
               end
            end
            if (slen == 0) begin
               sbuf[0] = alpha[0];
               slen    = 1;
            end
            for (int j = 0; j < slen; j++) begin
               if ($urandom_range(199) == 0) begin
                  send_req(OP_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)));
               end
               // once in a while the string runs on into the next one
               fin = (j == slen-1) && ($urandom_range(9) != 0);
               send_req(OP_TEXT, sbuf[j], fin);
            end
         end
      end

      // wind down
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         report($sformatf("%0d responses never came", pending_verdicts.size()));
      end
      if (mismatches == 0) begin
         $display("word_break_checker verification clean");
      end else begin
         $display("word_break_checker verification failed");
      end
      $finish;
   end

endmodule

@@ word_break_checker.f @@
hdl/wbc_pkg.sv
hdl/wbc_cell.sv
hdl/word_break_checker.sv
bench/tb_word_break_checker.sv
